[sv/msdt_pkg.sv]
// shared widths, codes, types and saturating add for the masked squared distance block
package msdt_pkg;

  localparam int VAL_W       = 16;
  localparam int DIFF_W      = VAL_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SQ_W        = 2 * VAL_W + 1;
  localparam int SUM_W       = 44;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 1'd1;

  // dimension selection modes
  localparam logic [MODE_W-1:0] MODE_ALL       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLAGGED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNFLAGGED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;

  typedef logic [SUM_W-1:0] sum_t;

  // one squared difference on its way to the accumulator
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            flag;
    logic            last;
  } sq_item_t;

  // sums of one finished vector pair
  typedef struct packed {
    sum_t sum_flagged;
    sum_t sum_unflagged;
    logic all_flagged;
  } totals_t;

  // add that clamps at the largest sum
  function automatic sum_t sat_add(input sum_t x, input sum_t y);
    logic [SUM_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

[sv/msdt_accum.sv]
// accumulator of flagged and unflagged squared differences with a totals register
module msdt_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  msdt_pkg::sq_item_t item,
  output logic               item_take,
  output logic               totals_valid,
  input  logic               totals_ready,
  output msdt_pkg::totals_t  totals
);

  msdt_pkg::sum_t sum_flagged;
  msdt_pkg::sum_t sum_unflagged;
  logic           all_flagged;

  msdt_pkg::sum_t sq_ext;
  msdt_pkg::sum_t sum_flagged_next;
  msdt_pkg::sum_t sum_unflagged_next;
  logic           all_flagged_next;
  logic           hold_free;

  // add this dimension to the sum that its flag picks
  always_comb begin
    sq_ext             = {{(msdt_pkg::SUM_W - msdt_pkg::SQ_W){1'b0}}, item.sq};
    sum_flagged_next   = sum_flagged;
    sum_unflagged_next = sum_unflagged;
    all_flagged_next   = all_flagged;
    if (item.flag) begin
      sum_flagged_next = msdt_pkg::sat_add(sum_flagged, sq_ext);
    end else begin
      sum_unflagged_next = msdt_pkg::sat_add(sum_unflagged, sq_ext);
      all_flagged_next   = 1'b0;
    end
  end

  // a last item waits only when the totals register is still occupied
  assign hold_free = !totals_valid || totals_ready;
  assign item_take = item_valid && (!item.last || hold_free);

  // running sums, cleared after each last item
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_flagged   <= '0;
      sum_unflagged <= '0;
      all_flagged   <= 1'b1;
      totals_valid  <= 1'b0;
    end else begin
      if (hold_free) begin
        totals_valid <= item_take && item.last;
      end
      if (item_take) begin
        if (item.last) begin
          sum_flagged   <= '0;
          sum_unflagged <= '0;
          all_flagged   <= 1'b1;
        end else begin
          sum_flagged   <= sum_flagged_next;
          sum_unflagged <= sum_unflagged_next;
          all_flagged   <= all_flagged_next;
        end
      end
    end
  end

  // totals of the finished vector pair
  always_ff @(posedge clk) begin
    if (item_take && item.last) begin
      totals.sum_flagged   <= sum_flagged_next;
      totals.sum_unflagged <= sum_unflagged_next;
      totals.all_flagged   <= all_flagged_next;
    end
  end

endmodule

[sv/masked_squared_distance_threshold.sv]
// top level: masked squared distance of two streamed vectors against a threshold
//
// Input channel (in_valid / in_ready) carries one dimension per request:
// value_a, value_b (Q8.8 signed), in_pattern (dimension is flagged) and
// last (final dimension of the vector pair). Only a request with last set
// produces a result on the output channel (out_valid / out_ready):
// exceeded, and distance (Q28.16 sum of squared differences, zero when
// exceeded is set). Sums saturate at 2^44 - 1.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 writes the
// 44-bit threshold max_distance, index 1 writes the 2-bit mode (0 all
// dimensions, 1 flagged only, 2 unflagged only or all if every dimension
// was flagged, 3 as 0). Write it only while the block is idle.
// Throughput: one request per cycle while the receiver keeps up, set by the
// single multiply and the accumulate that each dimension needs.
// Pipeline: a last request passes the input register and then the square,
// accumulate and compare stages, each registered, to reach the output.
// When the receiver stalls, the result register holds and the pipeline
// keeps filling; the totals register takes one more result, a further last
// request stalls in the accumulator, and in_ready falls once the stages
// in front of it are full.
// Reset clears the sums, the pipeline valids, threshold and mode.
module masked_squared_distance_threshold (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [msdt_pkg::VAL_W-1:0]     value_a,
  input  logic signed [msdt_pkg::VAL_W-1:0]     value_b,
  input  logic                                  in_pattern,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  exceeded,
  output logic [msdt_pkg::SUM_W-1:0]            distance,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msdt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [msdt_pkg::SUM_W-1:0]            cfg_data
);

  // configuration registers
  msdt_pkg::sum_t              max_distance;
  logic [msdt_pkg::MODE_W-1:0] mode;

  // input register stage
  logic                              in_stage_valid;
  logic signed [msdt_pkg::VAL_W-1:0] a_reg;
  logic signed [msdt_pkg::VAL_W-1:0] b_reg;
  logic                              pattern_reg;
  logic                              last_reg;

  // square stage
  logic                               sq_stage_valid;
  msdt_pkg::sq_item_t                 sq_stage;
  logic signed [msdt_pkg::DIFF_W-1:0] diff;
  logic signed [msdt_pkg::PROD_W-1:0] prod;

  // accumulator handshake and totals
  logic              item_take;
  logic              totals_valid;
  msdt_pkg::totals_t totals;

  // output stage
  msdt_pkg::sum_t combined;
  msdt_pkg::sum_t selected;
  logic           out_free;
  logic           sq_free;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= '0;
      mode         <= msdt_pkg::MODE_ALL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msdt_pkg::REG_MAX_DISTANCE: max_distance <= cfg_data;
        msdt_pkg::REG_MODE:         mode <= cfg_data[msdt_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: each stage loads when empty or when its content moves on
  assign out_free = !out_valid || out_ready;
  assign sq_free  = !sq_stage_valid || item_take;
  assign in_ready = !in_stage_valid || sq_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage_valid <= 1'b0;
    end else if (in_ready) begin
      in_stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_reg       <= value_a;
      b_reg       <= value_b;
      pattern_reg <= in_pattern;
      last_reg    <= last;
    end
  end

  // exact difference and square
  assign diff = msdt_pkg::DIFF_W'(a_reg) - msdt_pkg::DIFF_W'(b_reg);
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_stage_valid <= 1'b0;
    end else if (sq_free) begin
      sq_stage_valid <= in_stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_free && in_stage_valid) begin
      sq_stage.sq   <= prod[msdt_pkg::SQ_W-1:0];
      sq_stage.flag <= pattern_reg;
      sq_stage.last <= last_reg;
    end
  end

  msdt_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (sq_stage_valid),
    .item         (sq_stage),
    .item_take    (item_take),
    .totals_valid (totals_valid),
    .totals_ready (out_free),
    .totals       (totals)
  );

  // pick the sum that the mode asks for
  assign combined = msdt_pkg::sat_add(totals.sum_flagged, totals.sum_unflagged);

  always_comb begin
    unique case (mode)
      msdt_pkg::MODE_FLAGGED:   selected = totals.sum_flagged;
      msdt_pkg::MODE_UNFLAGGED: selected = totals.all_flagged ? totals.sum_flagged
                                                              : totals.sum_unflagged;
      msdt_pkg::MODE_ALL,
      msdt_pkg::MODE_SPARE:     selected = combined;
      default:                  selected = combined;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= totals_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && totals_valid) begin
      exceeded <= selected > max_distance;
      distance <= (selected > max_distance) ? '0 : selected;
    end
  end

`ifndef NO_ASSERTIONS
  // a threshold hit never reports a distance
  assert property (@(posedge clk) disable iff (rst)
    out_valid && exceeded |-> distance == '0)
    else $error("distance not zero on exceeded result");

  // a reported distance lies within the threshold
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !exceeded |-> distance <= max_distance)
    else $error("reported distance above threshold");

  // finished totals are not lost while the result register is stalled
  assert property (@(posedge clk) disable iff (rst)
    totals_valid && !out_free |=> totals_valid && $stable(totals))
    else $error("totals changed while stalled");

  // an empty input stage always takes a request
  assert property (@(posedge clk) disable iff (rst)
    !in_stage_valid |-> in_ready)
    else $error("input stalled while empty");
`endif

endmodule
